[rtl/scb_pkg.sv]
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types and constants of the scaled color-key sprite blitter.
// ----------------------------------------------------------------------------
package scb_pkg;

    localparam int POS_W   = 12;  // rect_x, rect_y
    localparam int DIM_W   = 11;  // rect_width, rect_height
    localparam int SRC_W   = 7;   // source_width, source_height
    localparam int PIX_W   = 32;
    localparam int IDX_W   = 12;  // load_index
    localparam int DEST_W  = 11;
    localparam int QUOT_W  = 7;   // scaled source coordinate, below source size
    localparam int SIDX_W  = 15;  // sy * source_width + sx

    localparam int REG_IDX_W = 3;
    localparam logic [REG_IDX_W-1:0] REG_RECT_X   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RECT_Y   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RECT_W   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RECT_H   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SRC_W    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_SRC_H    = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ALPHA    = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_OPAQUE   = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0] rect_x;
        logic [POS_W-1:0] rect_y;
        logic [DIM_W-1:0] rect_w;
        logic [DIM_W-1:0] rect_h;
        logic [SRC_W-1:0] src_w;
        logic [SRC_W-1:0] src_h;
        logic [PIX_W-1:0] alpha;
        logic             opaque;
    } t_cfg;

    typedef struct packed {
        logic load_wr;    // load item accepted: write sprite buffer
        logic tick_acc;   // tick item accepted: normalize walk position
        logic div_start;  // launch divider
        logic div_y;      // divider operands for the row axis
        logic latch_sx;
        logic latch_sy;
        logic calc_addr;
        logic mem_read;
        logic emit;       // produce result and step the walk
    } t_cmd;

    typedef struct packed {
        logic empty;      // nothing to draw with current registers
        logic div_done;
    } t_stat;

endpackage

[rtl/scb_regs.sv]
// ----------------------------------------------------------------------------
// scb_regs
// APB register file holding the blitter configuration.
// ----------------------------------------------------------------------------
module scb_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output scb_pkg::t_cfg    o_cfg
);
    import scb_pkg::*;

    t_cfg                 r_cfg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_RECT_X: r_cfg.rect_x <= pwdata[POS_W-1:0];
                REG_RECT_Y: r_cfg.rect_y <= pwdata[POS_W-1:0];
                REG_RECT_W: r_cfg.rect_w <= pwdata[DIM_W-1:0];
                REG_RECT_H: r_cfg.rect_h <= pwdata[DIM_W-1:0];
                REG_SRC_W:  r_cfg.src_w  <= pwdata[SRC_W-1:0];
                REG_SRC_H:  r_cfg.src_h  <= pwdata[SRC_W-1:0];
                REG_ALPHA:  r_cfg.alpha  <= pwdata;
                REG_OPAQUE: r_cfg.opaque <= pwdata[0];
                default:    r_cfg        <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_RECT_X: prdata = 32'(r_cfg.rect_x);
            REG_RECT_Y: prdata = 32'(r_cfg.rect_y);
            REG_RECT_W: prdata = 32'(r_cfg.rect_w);
            REG_RECT_H: prdata = 32'(r_cfg.rect_h);
            REG_SRC_W:  prdata = 32'(r_cfg.src_w);
            REG_SRC_H:  prdata = 32'(r_cfg.src_h);
            REG_ALPHA:  prdata = r_cfg.alpha;
            REG_OPAQUE: prdata = 32'(r_cfg.opaque);
            default:    prdata = '0;
        endcase
    end

endmodule

[rtl/scb_divider.sv]
// ----------------------------------------------------------------------------
// scb_divider
// Restoring divider, one quotient bit per cycle, for the scaled coordinate.
// ----------------------------------------------------------------------------
module scb_divider #(
    parameter int NUM_W = 17
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [NUM_W-1:0]           i_num,
    input  logic [scb_pkg::DIM_W-1:0]  i_den,
    output logic [scb_pkg::QUOT_W-1:0] o_quot,
    output logic                       o_done
);
    import scb_pkg::*;

    localparam int TW  = NUM_W + DIM_W;
    localparam int CNW = $clog2(QUOT_W);

    logic [TW-1:0]     r_rem;
    logic [TW-1:0]     r_den_sh;
    logic [QUOT_W-1:0] r_quot;
    logic [CNW-1:0]    r_cnt;
    logic              r_busy;
    logic              r_done;
    logic              fits;

    // quotient is known to stay below 2**QUOT_W, so QUOT_W steps suffice
    assign fits   = r_rem >= r_den_sh;
    assign o_quot = r_quot;
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem    <= TW'(i_num);
            r_den_sh <= TW'(i_den) << (QUOT_W - 1);
            r_quot   <= '0;
            r_cnt    <= CNW'(QUOT_W - 1);
        end else if (r_busy) begin
            if (fits) begin
                r_rem <= r_rem - r_den_sh;
            end
            r_quot   <= {r_quot[QUOT_W-2:0], fits};
            r_den_sh <= r_den_sh >> 1;
            r_cnt    <= r_cnt - 1'b1;
        end
    end

endmodule

[rtl/scb_datapath.sv]
// ----------------------------------------------------------------------------
// scb_datapath
// Walk counters, scaling divider, sprite buffer and result register.
// ----------------------------------------------------------------------------
module scb_datapath #(
    parameter int SPRITE_PIXELS  = 4096,
    parameter int MAX_RECT_DIM   = 1024,
    parameter int SURFACE_WIDTH  = 640,
    parameter int SURFACE_HEIGHT = 480
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  scb_pkg::t_cfg              i_cfg,
    input  scb_pkg::t_cmd              i_cmd,
    output scb_pkg::t_stat             o_stat,
    input  logic [scb_pkg::IDX_W-1:0]  i_load_index,
    input  logic [scb_pkg::PIX_W-1:0]  i_pixel_value,
    output logic                       o_result_valid,
    output logic [scb_pkg::DEST_W-1:0] o_dest_x,
    output logic [scb_pkg::DEST_W-1:0] o_dest_y,
    output logic [scb_pkg::PIX_W-1:0]  o_write_pixel,
    output logic                       o_write_enable,
    output logic                       o_last
);
    import scb_pkg::*;

    localparam int AW    = $clog2(SPRITE_PIXELS);
    localparam int CW    = $clog2(MAX_RECT_DIM);
    localparam int NUM_W = CW + SRC_W;
    localparam int EW    = (CW + 2 > 13) ? CW + 2 : 13;

    logic [PIX_W-1:0] mem [SPRITE_PIXELS];

    logic [CW-1:0]     r_col;
    logic [CW-1:0]     r_row;
    logic [QUOT_W-1:0] r_sx;
    logic [QUOT_W-1:0] r_sy;
    logic [SIDX_W-1:0] r_sidx;
    logic              r_sidx_ok;
    logic [PIX_W-1:0]  r_rdata;
    logic              r_rd_ok;

    logic              r_valid;
    logic [DEST_W-1:0] r_dest_x;
    logic [DEST_W-1:0] r_dest_y;
    logic [PIX_W-1:0]  r_pixel;
    logic              r_we;
    logic              r_last;

    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [CW-1:0]     col_n;
    logic [CW-1:0]     row_n;
    logic [NUM_W-1:0]  div_num;
    logic [DIM_W-1:0]  div_den;
    logic [QUOT_W-1:0] quot;
    logic              div_done;
    logic [SIDX_W-1:0] sidx;
    logic [31:0]       load_ext;
    logic [31:0]       sidx_ext;
    logic [PIX_W-1:0]  pixel;
    logic signed [EW-1:0] dx;
    logic signed [EW-1:0] dy;
    logic              on_surface;
    logic              visible;
    logic              col_end;
    logic              row_end;

    // rectangle size saturates at the largest supported dimension
    assign w = (32'(i_cfg.rect_w) > MAX_RECT_DIM) ? DIM_W'(MAX_RECT_DIM) : i_cfg.rect_w;
    assign h = (32'(i_cfg.rect_h) > MAX_RECT_DIM) ? DIM_W'(MAX_RECT_DIM) : i_cfg.rect_h;

    assign o_stat.empty    = (w == '0) || (h == '0) || (i_cfg.src_w == '0) ||
                             (i_cfg.src_h == '0);
    assign o_stat.div_done = div_done;

    // a register change may leave the walk past the rectangle
    assign col_n = (32'(r_col) >= 32'(w)) ? '0 : r_col;
    assign row_n = (32'(r_row) >= 32'(h)) ? '0 : r_row;

    assign div_num = i_cmd.div_y ? NUM_W'(r_row * i_cfg.src_h)
                                 : NUM_W'(r_col * i_cfg.src_w);
    assign div_den = i_cmd.div_y ? h : w;

    scb_divider #(
        .NUM_W (NUM_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quot  (quot),
        .o_done  (div_done)
    );

    assign sidx     = SIDX_W'(r_sy * i_cfg.src_w) + SIDX_W'(r_sx);
    assign load_ext = 32'(i_load_index);
    assign sidx_ext = 32'(r_sidx);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && (load_ext < SPRITE_PIXELS)) begin
            mem[load_ext[AW-1:0]] <= i_pixel_value;
        end
        if (i_cmd.mem_read) begin
            r_rdata <= mem[sidx_ext[AW-1:0]];
            r_rd_ok <= r_sidx_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_sx) begin
            r_sx <= quot;
        end
        if (i_cmd.latch_sy) begin
            r_sy <= quot;
        end
        if (i_cmd.calc_addr) begin
            r_sidx    <= sidx;
            r_sidx_ok <= 32'(sidx) < SPRITE_PIXELS;
        end
    end

    assign pixel      = r_rd_ok ? r_rdata : '0;
    assign dx         = $signed({{(EW-POS_W){i_cfg.rect_x[POS_W-1]}}, i_cfg.rect_x}) +
                        $signed({{(EW-CW){1'b0}}, r_col});
    assign dy         = $signed({{(EW-POS_W){i_cfg.rect_y[POS_W-1]}}, i_cfg.rect_y}) +
                        $signed({{(EW-CW){1'b0}}, r_row});
    assign on_surface = (dx >= 0) && (dx < $signed(EW'(SURFACE_WIDTH))) &&
                        (dy >= 0) && (dy < $signed(EW'(SURFACE_HEIGHT)));
    assign visible    = i_cfg.opaque ||
                        ((i_cfg.alpha != '0) ? ((pixel & i_cfg.alpha) != '0) : (pixel != '0));
    assign col_end    = (32'(r_col) + 32'd1) >= 32'(w);
    assign row_end    = (32'(r_row) + 32'd1) >= 32'(h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.tick_acc) begin
                r_col <= col_n;
                r_row <= row_n;
            end else if (i_cmd.emit) begin
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + 1'b1;
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_dest_x <= on_surface ? dx[DEST_W-1:0] : '0;
            r_dest_y <= on_surface ? dy[DEST_W-1:0] : '0;
            r_pixel  <= on_surface ? pixel : '0;
            r_we     <= on_surface && visible;
            r_last   <= col_end && row_end;
        end
    end

    assign o_result_valid = r_valid;
    assign o_dest_x       = r_dest_x;
    assign o_dest_y       = r_dest_y;
    assign o_write_pixel  = r_pixel;
    assign o_write_enable = r_we;
    assign o_last         = r_last;

endmodule

[rtl/scb_ctrl.sv]
// ----------------------------------------------------------------------------
// scb_ctrl
// Item sequencer: load on accept; tick: two divides, address, read, emit.
// ----------------------------------------------------------------------------
module scb_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    input  logic           i_kind,
    output logic           busy,
    input  scb_pkg::t_stat i_stat,
    output scb_pkg::t_cmd  o_cmd
);
    import scb_pkg::*;

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_DIVX_GO   = 3'd1;
    localparam logic [2:0] S_DIVX_WAIT = 3'd2;
    localparam logic [2:0] S_DIVY_GO   = 3'd3;
    localparam logic [2:0] S_DIVY_WAIT = 3'd4;
    localparam logic [2:0] S_ADDR      = 3'd5;
    localparam logic [2:0] S_READ      = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       accept;

    assign busy   = r_state != S_IDLE;
    assign accept = start && !busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && !i_kind) begin
                    o_cmd.load_wr = 1'b1;
                end else if (accept && !i_stat.empty) begin
                    // a tick with nothing to draw gives no result
                    o_cmd.tick_acc = 1'b1;
                    n_state        = S_DIVX_GO;
                end
            end
            S_DIVX_GO: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIVX_WAIT;
            end
            S_DIVX_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.latch_sx = 1'b1;
                    n_state        = S_DIVY_GO;
                end
            end
            S_DIVY_GO: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_y     = 1'b1;
                n_state         = S_DIVY_WAIT;
            end
            S_DIVY_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.latch_sy = 1'b1;
                    n_state        = S_ADDR;
                end
            end
            S_ADDR: begin
                o_cmd.calc_addr = 1'b1;
                n_state         = S_READ;
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_OUT;
            end
            S_OUT: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

[rtl/scaled_colorkey_sprite_blitter.sv]
// ----------------------------------------------------------------------------
// scaled_colorkey_sprite_blitter
// Nearest-neighbor scaled sprite blit with surface clipping and color key.
// ----------------------------------------------------------------------------
// An item is taken at a rising edge with start high and busy low. A load
// item (kind 0) writes pixel_value into the sprite buffer in that same edge
// and leaves busy low, so loads go at one per cycle while no tick is busy.
// A tick item (kind 1) takes the next position of the row-major walk over
// the target rectangle: busy stays high through both divides, the address
// step and the buffer read, and falls as the result strobe o_result_valid
// rises, so no new item is taken before the tick is through. The tick time
// is set by the shared one-bit-per-cycle divider, run once per axis, then
// the buffer read. A tick while any size register is zero gives no result
// and busy stays low. The receiver cannot stall: each result is valid for
// its one cycle only. Reset clears the registers and the walk position; the
// buffer contents are undefined until loaded. Configuration goes through
// the APB port (pready always high), register i at byte address 4*i. The
// user must write it only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module scaled_colorkey_sprite_blitter #(
    parameter int SPRITE_PIXELS  = 4096,
    parameter int MAX_RECT_DIM   = 1024,
    parameter int SURFACE_WIDTH  = 640,
    parameter int SURFACE_HEIGHT = 480
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic                       i_kind,
    input  logic [scb_pkg::IDX_W-1:0]  i_load_index,
    input  logic [scb_pkg::PIX_W-1:0]  i_pixel_value,
    output logic                       o_result_valid,
    output logic [scb_pkg::DEST_W-1:0] o_dest_x,
    output logic [scb_pkg::DEST_W-1:0] o_dest_y,
    output logic [scb_pkg::PIX_W-1:0]  o_write_pixel,
    output logic                       o_write_enable,
    output logic                       o_last,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [4:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import scb_pkg::*;

    t_cfg  cfg;
    t_cmd  cmd;
    t_stat stat;

    scb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    scb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_kind  (i_kind),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    scb_datapath #(
        .SPRITE_PIXELS  (SPRITE_PIXELS),
        .MAX_RECT_DIM   (MAX_RECT_DIM),
        .SURFACE_WIDTH  (SURFACE_WIDTH),
        .SURFACE_HEIGHT (SURFACE_HEIGHT)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (cfg),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_load_index   (i_load_index),
        .i_pixel_value  (i_pixel_value),
        .o_result_valid (o_result_valid),
        .o_dest_x       (o_dest_x),
        .o_dest_y       (o_dest_y),
        .o_write_pixel  (o_write_pixel),
        .o_write_enable (o_write_enable),
        .o_last         (o_last)
    );

endmodule

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the scaled color-key sprite blitter. Loads and
// ticks are fed through the command port and registers through APB. A
// shadow copy of the blitter predicts every destination write and each
// strobed result is matched field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SPRITE_PIXELS  = 4096;
    localparam int MAX_RECT_DIM   = 1024;
    localparam int SURFACE_WIDTH  = 640;
    localparam int SURFACE_HEIGHT = 480;
    localparam int TICK_LATENCY   = 22;
    localparam int RANDOM_ITEMS   = 500;

    typedef struct packed {
        logic [scb_pkg::DEST_W-1:0] x;
        logic [scb_pkg::DEST_W-1:0] y;
        logic [scb_pkg::PIX_W-1:0]  pixel;
        logic                       enable;
        logic                       last;
    } blit_write_t;

    // Shadow of the blitter: registers, sprite buffer and walk position.
    class sprite_blit_shadow;
        scb_pkg::t_cfg             cfg = '0;
        logic [scb_pkg::PIX_W-1:0] sprite_mem [SPRITE_PIXELS];
        bit                        loaded [SPRITE_PIXELS];
        int unsigned               walk_col = 0;
        int unsigned               walk_row = 0;
        blit_write_t               due_writes [$];
        int                        mismatches = 0;

        task flag(string msg);
            $display("ERROR @%0t: %s", $time, msg);
            mismatches++;
        endtask

        function void apply_reg(logic [scb_pkg::REG_IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                scb_pkg::REG_RECT_X: cfg.rect_x = val[scb_pkg::POS_W-1:0];
                scb_pkg::REG_RECT_Y: cfg.rect_y = val[scb_pkg::POS_W-1:0];
                scb_pkg::REG_RECT_W: cfg.rect_w = val[scb_pkg::DIM_W-1:0];
                scb_pkg::REG_RECT_H: cfg.rect_h = val[scb_pkg::DIM_W-1:0];
                scb_pkg::REG_SRC_W:  cfg.src_w  = val[scb_pkg::SRC_W-1:0];
                scb_pkg::REG_SRC_H:  cfg.src_h  = val[scb_pkg::SRC_W-1:0];
                scb_pkg::REG_ALPHA:  cfg.alpha  = val;
                scb_pkg::REG_OPAQUE: cfg.opaque = val[0];
                default: ;
            endcase
        endfunction

        function void take_item(bit kind, logic [scb_pkg::IDX_W-1:0] idx,
                                logic [scb_pkg::PIX_W-1:0] pix);
            int unsigned w, h, sw, sh, col, row, sidx;
            int          dx, dy;
            logic [31:0] p;
            bit          on_surface, vis, at_end;
            blit_write_t r;
            if (kind == 1'b0) begin
                sprite_mem[idx] = pix;
                loaded[idx] = 1'b1;
                return;
            end
            w  = (cfg.rect_w > MAX_RECT_DIM) ? MAX_RECT_DIM : cfg.rect_w;
            h  = (cfg.rect_h > MAX_RECT_DIM) ? MAX_RECT_DIM : cfg.rect_h;
            sw = cfg.src_w;
            sh = cfg.src_h;
            if (w == 0 || h == 0 || sw == 0 || sh == 0)
                return;
            // a size change may leave the walk outside the rectangle
            if (walk_col >= w) walk_col = 0;
            if (walk_row >= h) walk_row = 0;
            col  = walk_col;
            row  = walk_row;
            sidx = (row * sh / h) * sw + col * sw / w;
            p    = (sidx < SPRITE_PIXELS) ? sprite_mem[sidx] : '0;
            dx   = int'($signed(cfg.rect_x)) + int'(col);
            dy   = int'($signed(cfg.rect_y)) + int'(row);
            on_surface = dx >= 0 && dx < SURFACE_WIDTH && dy >= 0 && dy < SURFACE_HEIGHT;
            at_end = (col == w - 1) && (row == h - 1);
            if (cfg.opaque)
                vis = 1'b1;
            else if (cfg.alpha != 0)
                vis = (p & cfg.alpha) != 0;
            else
                vis = p != 0;
            if (on_surface)
                r = '{dx[scb_pkg::DEST_W-1:0], dy[scb_pkg::DEST_W-1:0], p, vis, at_end};
            else
                r = '{0, 0, 0, 1'b0, at_end};
            due_writes.push_back(r);
            walk_col = col + 1;
            if (walk_col >= w) begin
                walk_col = 0;
                walk_row = row + 1;
                if (walk_row >= h) walk_row = 0;
            end
        endfunction

        task compare(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                flag($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task match_write(blit_write_t got);
            blit_write_t want;
            if (due_writes.size() == 0) begin
                flag("destination write with nothing expected");
                return;
            end
            want = due_writes.pop_front();
            compare("dest_x", 32'(got.x), 32'(want.x));
            compare("dest_y", 32'(got.y), 32'(want.y));
            compare("write_pixel", got.pixel, want.pixel);
            compare("write_enable", 32'(got.enable), 32'(want.enable));
            compare("last", 32'(got.last), 32'(want.last));
        endtask
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic                       i_kind;
    logic [scb_pkg::IDX_W-1:0]  i_load_index;
    logic [scb_pkg::PIX_W-1:0]  i_pixel_value;
    logic                       o_result_valid;
    logic [scb_pkg::DEST_W-1:0] o_dest_x;
    logic [scb_pkg::DEST_W-1:0] o_dest_y;
    logic [scb_pkg::PIX_W-1:0]  o_write_pixel;
    logic                       o_write_enable;
    logic                       o_last;
    logic                       psel;
    logic                       penable;
    logic                       pwrite;
    logic [4:0]                 paddr;
    logic [31:0]                pwdata;
    logic [31:0]                prdata;
    logic                       pready;

    sprite_blit_shadow shadow = new;
    int                sent_items = 0;

    scaled_colorkey_sprite_blitter #(
        .SPRITE_PIXELS (SPRITE_PIXELS),
        .MAX_RECT_DIM  (MAX_RECT_DIM),
        .SURFACE_WIDTH (SURFACE_WIDTH),
        .SURFACE_HEIGHT(SURFACE_HEIGHT)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_kind        (i_kind),
        .i_load_index  (i_load_index),
        .i_pixel_value (i_pixel_value),
        .o_result_valid(o_result_valid),
        .o_dest_x      (o_dest_x),
        .o_dest_y      (o_dest_y),
        .o_write_pixel (o_write_pixel),
        .o_write_enable(o_write_enable),
        .o_last        (o_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1)
            shadow.match_write(blit_write_t'{o_dest_x, o_dest_y, o_write_pixel,
                                             o_write_enable, o_last});
    end

    function automatic logic [31:0] rand_pixel();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 32'd1 << $urandom_range(0, 31);
            3: return ~(32'd1 << $urandom_range(0, 31));
            default: return $urandom;
        endcase
    endfunction

    function automatic int pick_pos(int span);
        case ($urandom_range(0, 7))
            0: return -2048;
            1: return 2047;
            2, 3: return $urandom_range(0, span) - 16;
            default: return $urandom_range(0, 40) - 8;
        endcase
    endfunction

    function automatic int pick_dim();
        case ($urandom_range(0, 15))
            0: return 0;
            1: return MAX_RECT_DIM;
            2: return $urandom_range(MAX_RECT_DIM + 1, 2047);
            3, 4: return $urandom_range(13, 70);
            default: return $urandom_range(1, 12);
        endcase
    endfunction

    function automatic int pick_src();
        case ($urandom_range(0, 15))
            0: return 0;
            1: return 64;
            2, 3: return $urandom_range(9, 63);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    function automatic logic [31:0] pick_mask();
        case ($urandom_range(0, 7))
            0, 1: return '0;
            2: return '1;
            3: return 32'd1 << $urandom_range(0, 31);
            4: return 32'hFF00_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(bit kind, logic [scb_pkg::IDX_W-1:0] idx,
                             logic [scb_pkg::PIX_W-1:0] pix);
        @(negedge i_clk);
        start         = 1'b1;
        i_kind        = kind;
        i_load_index  = idx;
        i_pixel_value = pix;
        do @(posedge i_clk); while (busy !== 1'b0);
        shadow.take_item(kind, idx, pix);
        sent_items++;
    endtask

    task automatic idle_cycles(int n);
        repeat (n) begin
            @(negedge i_clk);
            start         = 1'b0;
            i_kind        = $urandom_range(0, 1);
            i_load_index  = $urandom;
            i_pixel_value = $urandom;
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (shadow.due_writes.size() != 0)
            @(posedge i_clk);
    endtask

    // empty ticks leave no result behind, so also wait out a tick latency
    task automatic settle();
        drain();
        repeat (TICK_LATENCY + 8) @(posedge i_clk);
    endtask

    // upper pwdata bits beyond the register width carry noise
    task automatic write_reg(logic [scb_pkg::REG_IDX_W-1:0] idx, int val);
        int          w;
        logic [31:0] keep;
        logic [31:0] data;
        case (idx)
            scb_pkg::REG_RECT_X, scb_pkg::REG_RECT_Y: w = scb_pkg::POS_W;
            scb_pkg::REG_RECT_W, scb_pkg::REG_RECT_H: w = scb_pkg::DIM_W;
            scb_pkg::REG_SRC_W, scb_pkg::REG_SRC_H:   w = scb_pkg::SRC_W;
            scb_pkg::REG_ALPHA:                       w = scb_pkg::PIX_W;
            default:                                  w = 1;
        endcase
        keep = (w == 32) ? '1 : ((32'd1 << w) - 1);
        data = (32'(val) & keep) | ($urandom & ~keep);
        @(negedge i_clk);
        start   = 1'b0;
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        shadow.apply_reg(idx, data);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic fill_sprite();
        int n;
        n = shadow.cfg.src_w * shadow.cfg.src_h;
        for (int i = 0; i < n; i++) begin
            if (!shadow.loaded[i])
                send_item(1'b0, i, rand_pixel());
        end
    endtask

    // a wide sprite gets a short height to keep the buffer fill small
    task automatic random_setting();
        settle();
        write_reg(scb_pkg::REG_RECT_X, pick_pos(660));
        write_reg(scb_pkg::REG_RECT_Y, pick_pos(500));
        write_reg(scb_pkg::REG_RECT_W, pick_dim());
        write_reg(scb_pkg::REG_RECT_H, pick_dim());
        write_reg(scb_pkg::REG_SRC_W, pick_src());
        write_reg(scb_pkg::REG_SRC_H,
                  (shadow.cfg.src_w > 8) ? $urandom_range(0, 4) : pick_src());
        write_reg(scb_pkg::REG_ALPHA, pick_mask());
        write_reg(scb_pkg::REG_OPAQUE, $urandom_range(0, 3) == 0);
        fill_sprite();
    endtask

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int  n;
        int  region;
        int  idle_pct;
        bit  quiet;
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_kind        = 1'b0;
        i_load_index  = '0;
        i_pixel_value = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // all sizes zero after reset: nothing drawn
        send_item(1'b1, $urandom, $urandom);

        write_reg(scb_pkg::REG_RECT_X, -1);
        write_reg(scb_pkg::REG_RECT_Y, 478);
        write_reg(scb_pkg::REG_RECT_W, 3);
        write_reg(scb_pkg::REG_RECT_H, 3);
        write_reg(scb_pkg::REG_SRC_W, 2);
        write_reg(scb_pkg::REG_SRC_H, 2);
        write_reg(scb_pkg::REG_ALPHA, 0);
        write_reg(scb_pkg::REG_OPAQUE, 0);
        send_item(1'b0, 0, 32'h0000_0000);
        send_item(1'b0, 1, 32'hFFFF_FFFF);
        send_item(1'b0, 2, 32'h0000_0001);
        send_item(1'b0, 3, 32'h8000_0000);
        // left and bottom clipping, zero color key, walk end and wrap
        repeat (10) send_item(1'b1, $urandom, $urandom);

        settle();
        // column left beyond the narrowed rectangle
        write_reg(scb_pkg::REG_RECT_W, 1);
        write_reg(scb_pkg::REG_RECT_X, 0);
        write_reg(scb_pkg::REG_RECT_Y, 0);
        write_reg(scb_pkg::REG_ALPHA, 32'hFF00_0000);
        repeat (3) send_item(1'b1, $urandom, $urandom);

        settle();
        write_reg(scb_pkg::REG_OPAQUE, 1);
        write_reg(scb_pkg::REG_SRC_W, 0);
        send_item(1'b1, $urandom, $urandom);
        settle();
        write_reg(scb_pkg::REG_SRC_W, 2);
        write_reg(scb_pkg::REG_RECT_X, 2047);
        write_reg(scb_pkg::REG_RECT_Y, -2048);
        write_reg(scb_pkg::REG_RECT_W, 2047);
        repeat (2) send_item(1'b1, $urandom, $urandom);
        settle();
        write_reg(scb_pkg::REG_RECT_X, -2048);
        write_reg(scb_pkg::REG_RECT_Y, 2047);
        send_item(1'b1, $urandom, $urandom);
        settle();
        write_reg(scb_pkg::REG_RECT_X, 0);
        write_reg(scb_pkg::REG_RECT_Y, 0);
        send_item(1'b1, $urandom, $urandom);
        send_item(1'b0, 4095, 32'hFFFF_FFFF);

        // oversized row: saturated scaling, clipped at the right surface edge
        settle();
        write_reg(scb_pkg::REG_RECT_X, 600);
        write_reg(scb_pkg::REG_RECT_Y, 470);
        write_reg(scb_pkg::REG_RECT_W, 2047);
        write_reg(scb_pkg::REG_RECT_H, 1);
        write_reg(scb_pkg::REG_SRC_W, 64);
        write_reg(scb_pkg::REG_SRC_H, 1);
        write_reg(scb_pkg::REG_ALPHA, 0);
        write_reg(scb_pkg::REG_OPAQUE, 0);
        fill_sprite();
        repeat (48) send_item(1'b1, $urandom, $urandom);

        while (sent_items < RANDOM_ITEMS) begin
            random_setting();
            quiet    = sent_items >= RANDOM_ITEMS * 4 / 5;
            idle_pct = (quiet || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(10, 40);
            region   = shadow.cfg.src_w * shadow.cfg.src_h;
            n        = $urandom_range(15, 50);
            repeat (n) begin
                if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct)
                    idle_cycles($urandom_range(1, 5));
                if (!quiet && $urandom_range(0, 49) == 0)
                    drain();
                if ($urandom_range(0, 9) < 7)
                    send_item(1'b1, $urandom, $urandom);
                else if (region > 0 && $urandom_range(0, 3) != 0)
                    send_item(1'b0, $urandom_range(0, region - 1), rand_pixel());
                else
                    send_item(1'b0, $urandom, rand_pixel());
            end
        end

        drain();
        repeat (TICK_LATENCY + 16) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.due_writes.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
